/* rtl/lmgfp_pkg.sv */
// shared types, constants and the microcode rom of the gray frame packer
// no dependencies: every other file refers to this package by scoped names
`timescale 1ns / 1ps

package lmgfp_pkg;

   localparam int LED_COUNT   = 64;
   localparam int LED_ADDR_W  = 6;
   localparam int LEVEL_W     = 4;
   localparam int GRAY_W      = 12;
   localparam int COL_W       = 2;
   localparam int SLOT_W      = 4;
   localparam int PAIRS       = 8;
   localparam int PAIR_W      = 3;
   localparam int STEP_W      = 2;

   // item kinds
   localparam logic [1:0] KIND_SET_ONE = 2'd0;
   localparam logic [1:0] KIND_SET_ALL = 2'd1;
   localparam logic [1:0] KIND_TICK    = 2'd2;

   // power states seen at a tick
   localparam logic [1:0] POWER_OFF = 2'd0;
   localparam logic [1:0] POWER_ON  = 2'd1;

   // microcode steps
   localparam logic [STEP_W-1:0] STEP_HEAD   = 2'd0;
   localparam logic [STEP_W-1:0] STEP_A_HIGH = 2'd1;
   localparam logic [STEP_W-1:0] STEP_MIDDLE = 2'd2;
   localparam logic [STEP_W-1:0] STEP_B_LOW  = 2'd3;

   typedef struct packed {
      logic [1:0]            kind;
      logic [LED_ADDR_W-1:0] led_index;
      logic [LEVEL_W-1:0]    level;
      logic [1:0]            power_state;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      SEL_COLUMN,
      SEL_A_HIGH,
      SEL_MIDDLE,
      SEL_B_LOW
   } emit_sel_type;

   typedef enum logic {
      JUMP_NEXT,
      JUMP_LOOP
   } jump_type;

   typedef struct packed {
      emit_sel_type       sel;
      logic               rd_en;
      logic               latch_a;
      logic               latch_b;
      jump_type           jump;
      logic [STEP_W-1:0]  target;
   } ucode_word_type;

   // sequencer to datapath and level store
   typedef struct packed {
      logic                  emit;
      emit_sel_type          sel;
      logic                  last;
      logic                  blank;
      logic [COL_W-1:0]      col;
      logic                  latch_a;
      logic                  latch_b;
      logic                  rd_en;
      logic [LED_ADDR_W-1:0] rd_addr;
   } ctrl_type;

   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      w = '0;
      unique case (step)
         STEP_HEAD: begin
            w.sel = SEL_COLUMN; w.rd_en = 1'b1; w.latch_a = 1'b1;
            w.jump = JUMP_NEXT; w.target = STEP_A_HIGH;
         end
         STEP_A_HIGH: begin
            w.sel = SEL_A_HIGH; w.rd_en = 1'b1; w.latch_b = 1'b1;
            w.jump = JUMP_NEXT; w.target = STEP_MIDDLE;
         end
         STEP_MIDDLE: begin
            w.sel = SEL_MIDDLE; w.latch_a = 1'b1;
            w.jump = JUMP_NEXT; w.target = STEP_B_LOW;
         end
         STEP_B_LOW: begin
            w.sel = SEL_B_LOW; w.rd_en = 1'b1;
            w.jump = JUMP_LOOP; w.target = STEP_A_HIGH;
         end
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [GRAY_W-1:0] gamma(input logic [LEVEL_W-1:0] level);
      logic [GRAY_W-1:0] g;
      unique case (level)
         4'd0:  g = 12'd0;
         4'd1:  g = 12'd14;
         4'd2:  g = 12'd35;
         4'd3:  g = 12'd62;
         4'd4:  g = 12'd99;
         4'd5:  g = 12'd150;
         4'd6:  g = 12'd219;
         4'd7:  g = 12'd313;
         4'd8:  g = 12'd441;
         4'd9:  g = 12'd614;
         4'd10: g = 12'd849;
         4'd11: g = 12'd1170;
         4'd12: g = 12'd1605;
         4'd13: g = 12'd2197;
         4'd14: g = 12'd3002;
         4'd15: g = 12'd4095;
         default: g = '0;
      endcase
      return g;
   endfunction

   function automatic logic [7:0] select_pattern(input logic [COL_W-1:0] col);
      logic [7:0] p;
      unique case (col)
         2'd0: p = 8'b1101_1101;
         2'd1: p = 8'b1011_1011;
         2'd2: p = 8'b0111_0111;
         2'd3: p = 8'b1110_1110;
         default: p = '0;
      endcase
      return p;
   endfunction

   // odd columns run their leds in descending order
   function automatic logic [LED_ADDR_W-1:0] led_addr(input logic [COL_W-1:0] col,
                                                      input logic [SLOT_W-1:0] slot);
      return {col, (col[0] ? ~slot : slot)};
   endfunction

endpackage

/* rtl/led_matrix_gray_frame_packer.sv */
// top level of the gray frame packer for a four-column 64-led matrix
// depends on lmgfp_pkg, lmgfp_level_store, lmgfp_sequencer, lmgfp_datapath
`timescale 1ns / 1ps

// usage
//   an item is taken on a rising edge with start high and busy low
//   set one led / set all leds: the 4-bit step is stored, busy
//     never rises, the next item may follow on the next edge
//   tick with power on: 25 bytes, column select pattern then 16 levels packed
//     two 12-bit values into three bytes; odd columns run in descending order
//   tick in a transitional power state: select pattern of column 0, 24 zeros
//   tick with power off: nothing is sent and the column stays
// frame output
//   the accepting edge sets the sequencer running, the output register then takes
//   the column byte, and one byte follows every cycle with no gaps, last marking
//   the 25th; busy stays high with one microcode step per byte and three per
//   level pair over a single read port of the store, and drops only after the
//   last step, so no new item is taken until the frame's last step is done
// output side
//   each byte is valid for exactly one cycle under rsp_strobe; the receiver
//   cannot stall, so it must take every strobed byte
// reset
//   synchronous, active high: all levels read as zero, column 0, idle

module led_matrix_gray_frame_packer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  lmgfp_pkg::req_type   req_item,
   output logic                 rsp_strobe,
   output lmgfp_pkg::rsp_type   rsp_item
);

   lmgfp_pkg::ctrl_type              ctrl;
   logic [lmgfp_pkg::LEVEL_W-1:0]    rd_level;
   logic                             accept;
   logic                             wr_one;
   logic                             wr_all;

   // set items go straight into the level store
   assign accept = start && !busy;
   assign wr_one = accept && (req_item.kind == lmgfp_pkg::KIND_SET_ONE);
   assign wr_all = accept && (req_item.kind == lmgfp_pkg::KIND_SET_ALL);

   // program sequencer: walks the frame and issues store reads ahead of use
   lmgfp_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   // level store: one write port for set items, one registered read port
   lmgfp_level_store u_level_store (
      .clock    (clock),
      .reset    (reset),
      .wr_one   (wr_one),
      .wr_all   (wr_all),
      .wr_addr  (req_item.led_index),
      .wr_level (req_item.level),
      .rd_en    (ctrl.rd_en),
      .rd_addr  (ctrl.rd_addr),
      .rd_level (rd_level)
   );

   // gamma, packing and the output register
   lmgfp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .rd_level   (rd_level),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

/* rtl/lmgfp_level_store.sv */
// led level store: 4-bit steps in a 64-entry memory, valid bits and fill level
// depends on lmgfp_pkg
`timescale 1ns / 1ps

module lmgfp_level_store (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_one,
   input  logic                                wr_all,
   input  logic [lmgfp_pkg::LED_ADDR_W-1:0]    wr_addr,
   input  logic [lmgfp_pkg::LEVEL_W-1:0]       wr_level,
   input  logic                                rd_en,
   input  logic [lmgfp_pkg::LED_ADDR_W-1:0]    rd_addr,
   output logic [lmgfp_pkg::LEVEL_W-1:0]       rd_level
);

   logic [lmgfp_pkg::LEVEL_W-1:0]   level_mem_ff [lmgfp_pkg::LED_COUNT];
   logic [lmgfp_pkg::LEVEL_W-1:0]   rd_data_ff;
   logic                            hit_ff;
   logic [lmgfp_pkg::LED_COUNT-1:0] valid_ff;
   logic [lmgfp_pkg::LED_COUNT-1:0] valid_in;
   logic [lmgfp_pkg::LEVEL_W-1:0]   fill_ff;
   logic [lmgfp_pkg::LEVEL_W-1:0]   fill_in;

   always_ff @(posedge clock) begin
      if (wr_one) begin
         level_mem_ff[wr_addr] <= wr_level;
      end
      if (rd_en) begin
         rd_data_ff <= level_mem_ff[rd_addr];
         hit_ff     <= valid_ff[rd_addr];
      end
   end

   // a set-all item clears every valid bit and becomes the fill level
   always_comb begin
      valid_in = valid_ff;
      fill_in  = fill_ff;
      if (wr_all) begin
         valid_in = '0;
         fill_in  = wr_level;
      end else if (wr_one) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         fill_ff  <= fill_in;
      end
   end

   assign rd_level = hit_ff ? rd_data_ff : fill_ff;

endmodule

/* rtl/lmgfp_sequencer.sv */
// microcoded frame sequencer: step counter, pair loop, read address generation
// depends on lmgfp_pkg (microcode rom, address map)
`timescale 1ns / 1ps

module lmgfp_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  lmgfp_pkg::req_type   req_item,
   output logic                 busy,
   output lmgfp_pkg::ctrl_type  ctrl
);

   logic                              running_ff, running_in;
   logic [lmgfp_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [lmgfp_pkg::PAIR_W-1:0]      pair_ff, pair_in;
   logic [lmgfp_pkg::SLOT_W-1:0]      slot_ff, slot_in;
   logic [lmgfp_pkg::COL_W-1:0]       col_ff, col_in;
   logic                              blank_ff, blank_in;
   logic [lmgfp_pkg::COL_W-1:0]       active_col_ff, active_col_in;
   lmgfp_pkg::ucode_word_type         uword;
   logic                              tick_go;
   logic                              pair_done;

   assign tick_go = start && !running_ff && (req_item.kind == lmgfp_pkg::KIND_TICK)
                    && (req_item.power_state != lmgfp_pkg::POWER_OFF);
   assign uword     = lmgfp_pkg::ucode_rom(step_ff);
   assign pair_done = (pair_ff == lmgfp_pkg::PAIR_W'(lmgfp_pkg::PAIRS - 1));
   assign busy      = running_ff;

   // next state
   always_comb begin
      running_in    = running_ff;
      step_in       = step_ff;
      pair_in       = pair_ff;
      slot_in       = slot_ff;
      col_in        = col_ff;
      blank_in      = blank_ff;
      active_col_in = active_col_ff;
      if (tick_go) begin
         running_in    = 1'b1;
         step_in       = lmgfp_pkg::STEP_HEAD;
         pair_in       = '0;
         slot_in       = lmgfp_pkg::SLOT_W'(1);
         blank_in      = (req_item.power_state != lmgfp_pkg::POWER_ON);
         col_in        = (req_item.power_state != lmgfp_pkg::POWER_ON) ? '0 : active_col_ff;
         active_col_in = active_col_ff + lmgfp_pkg::COL_W'(1);
      end else if (running_ff) begin
         if (uword.rd_en) begin
            slot_in = slot_ff + lmgfp_pkg::SLOT_W'(1);
         end
         unique case (uword.jump)
            lmgfp_pkg::JUMP_NEXT: step_in = uword.target;
            lmgfp_pkg::JUMP_LOOP: begin
               if (pair_done) begin
                  running_in = 1'b0;
                  step_in    = lmgfp_pkg::STEP_HEAD;
               end else begin
                  step_in = uword.target;
                  pair_in = pair_ff + lmgfp_pkg::PAIR_W'(1);
               end
            end
            default: step_in = uword.target;
         endcase
      end
   end

   // control word out
   always_comb begin
      ctrl = '0;
      if (running_ff) begin
         ctrl.emit    = 1'b1;
         ctrl.sel     = uword.sel;
         ctrl.last    = (uword.jump == lmgfp_pkg::JUMP_LOOP) && pair_done;
         ctrl.blank   = blank_ff;
         ctrl.col     = col_ff;
         ctrl.latch_a = uword.latch_a;
         ctrl.latch_b = uword.latch_b;
         ctrl.rd_en   = uword.rd_en;
         ctrl.rd_addr = lmgfp_pkg::led_addr(col_ff, slot_ff);
      end else begin
         ctrl.sel     = lmgfp_pkg::SEL_COLUMN;
         ctrl.rd_en   = tick_go;
         ctrl.rd_addr = lmgfp_pkg::led_addr(active_col_ff, '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         step_ff       <= lmgfp_pkg::STEP_HEAD;
         pair_ff       <= '0;
         slot_ff       <= '0;
         col_ff        <= '0;
         blank_ff      <= 1'b0;
         active_col_ff <= '0;
      end else begin
         running_ff    <= running_in;
         step_ff       <= step_in;
         pair_ff       <= pair_in;
         slot_ff       <= slot_in;
         col_ff        <= col_in;
         blank_ff      <= blank_in;
         active_col_ff <= active_col_in;
      end
   end

   a_head_after_tick: assert property (@(posedge clock) disable iff (reset)
      (running_ff && step_ff == lmgfp_pkg::STEP_HEAD) |-> $past(tick_go))
      else $error("frame head without an accepted tick");

   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      ($fell(running_ff) && $past(!reset)) |-> $past(ctrl.last))
      else $error("frame ended before its last item");

   a_column_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(running_ff) |-> (active_col_ff == $past(active_col_ff) + lmgfp_pkg::COL_W'(1)))
      else $error("active column did not advance on a frame");

endmodule

/* rtl/lmgfp_datapath.sv */
// byte datapath: gamma lookup, level pair registers, byte select, output register
// depends on lmgfp_pkg (gamma and select tables, control struct)
`timescale 1ns / 1ps

module lmgfp_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  lmgfp_pkg::ctrl_type             ctrl,
   input  logic [lmgfp_pkg::LEVEL_W-1:0]   rd_level,
   output logic                            rsp_strobe,
   output lmgfp_pkg::rsp_type              rsp_item
);

   logic [lmgfp_pkg::GRAY_W-1:0] a_ff;
   logic [lmgfp_pkg::GRAY_W-1:0] b_ff;
   logic                         rsp_strobe_ff;
   lmgfp_pkg::rsp_type           rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (ctrl.latch_a) begin
         a_ff <= lmgfp_pkg::gamma(rd_level);
      end
      if (ctrl.latch_b) begin
         b_ff <= lmgfp_pkg::gamma(rd_level);
      end
   end

   // a[11:4], {a[3:0], b[11:8]}, b[7:0]
   always_comb begin
      rsp_in.last = ctrl.last;
      unique case (ctrl.sel)
         lmgfp_pkg::SEL_COLUMN: rsp_in.data_byte = lmgfp_pkg::select_pattern(ctrl.col);
         lmgfp_pkg::SEL_A_HIGH: rsp_in.data_byte = a_ff[11:4];
         lmgfp_pkg::SEL_MIDDLE: rsp_in.data_byte = {a_ff[3:0], b_ff[11:8]};
         lmgfp_pkg::SEL_B_LOW:  rsp_in.data_byte = b_ff[7:0];
         default:               rsp_in.data_byte = '0;
      endcase
      if (ctrl.blank && ctrl.sel != lmgfp_pkg::SEL_COLUMN) begin
         rsp_in.data_byte = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctrl.emit;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

/* bench/tb_top.sv */
// self-checking bench for the gray frame packer: directed and random set and tick items,
// with every frame byte predicted in the bench and compared field by field
// depends on lmgfp_pkg and led_matrix_gray_frame_packer
`timescale 1ns / 1ps

module tb_top;

   // item codes the package leaves unnamed
   localparam logic [1:0] KIND_UNUSED       = 2'd3;
   localparam logic [1:0] POWER_TRANSIT     = 2'd2;
   localparam logic [1:0] POWER_TRANSIT_ALT = 2'd3;

   localparam int FRAME_LEN    = 25;
   localparam int RANDOM_ITEMS = 300;
   localparam int CALM_TAIL    = 60;
   localparam int MAX_GAP      = 17;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   lmgfp_pkg::req_type req_item = '0;
   logic               busy;
   logic               rsp_strobe;
   lmgfp_pkg::rsp_type rsp_item;

   // mirror of the block's state
   bit [lmgfp_pkg::GRAY_W-1:0] gray_levels [lmgfp_pkg::LED_COUNT];
   bit [lmgfp_pkg::COL_W-1:0]  active_col = '0;

   bit [lmgfp_pkg::GRAY_W-1:0] gamma_steps [16] = '{12'd0, 12'd14, 12'd35, 12'd62, 12'd99,
                                         12'd150, 12'd219, 12'd313, 12'd441, 12'd614,
                                         12'd849, 12'd1170, 12'd1605, 12'd2197, 12'd3002,
                                         12'd4095};
   bit [7:0]        col_select [4] = '{8'hDD, 8'hBB, 8'h77, 8'hEE};

   lmgfp_pkg::rsp_type bytes_due [$];
   int      error_count = 0;
   int      cycle_count = 0;
   bit      gaps_enabled = 1'b0;

   led_matrix_gray_frame_packer u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // led number for a frame slot; odd columns count down from the top of their bank
   function automatic bit [lmgfp_pkg::LED_ADDR_W-1:0] led_slot(
                                          input bit [lmgfp_pkg::COL_W-1:0] col,
                                          input int slot);
      int base;
      base = int'(col) * 16;
      return lmgfp_pkg::LED_ADDR_W'(col[0] ? base + 15 - slot : base + slot);
   endfunction

   // applies one accepted item to the mirrored state and queues the bytes it causes
   task automatic predict_frame(input lmgfp_pkg::req_type item);
      bit [lmgfp_pkg::GRAY_W-1:0] a, b;
      bit [7:0]                   frame [FRAME_LEN];
      lmgfp_pkg::rsp_type         byte_out;
      case (item.kind)
         lmgfp_pkg::KIND_SET_ONE: gray_levels[item.led_index] = gamma_steps[item.level];
         lmgfp_pkg::KIND_SET_ALL: begin
            for (int i = 0; i < lmgfp_pkg::LED_COUNT; i++)
               gray_levels[i] = gamma_steps[item.level];
         end
         lmgfp_pkg::KIND_TICK: begin
            // power off: no frame and the column holds
            if (item.power_state != lmgfp_pkg::POWER_OFF) begin
               if (item.power_state == lmgfp_pkg::POWER_ON) begin
                  frame[0] = col_select[active_col];
                  for (int p = 0; p < lmgfp_pkg::PAIRS; p++) begin
                     a = gray_levels[led_slot(active_col, 2 * p)];
                     b = gray_levels[led_slot(active_col, 2 * p + 1)];
                     frame[1 + 3 * p] = a[11:4];
                     frame[2 + 3 * p] = {a[3:0], b[11:8]};
                     frame[3 + 3 * p] = b[7:0];
                  end
               end else begin
                  // transitional power: column 0 pattern, then blank
                  frame[0] = col_select[0];
                  for (int k = 1; k < FRAME_LEN; k++) frame[k] = 8'h00;
               end
               for (int k = 0; k < FRAME_LEN; k++) begin
                  byte_out.data_byte = frame[k];
                  byte_out.last      = (k == FRAME_LEN - 1);
                  bytes_due.push_back(byte_out);
               end
               active_col = active_col + 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : check_bytes
      lmgfp_pkg::rsp_type due;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (rsp_strobe !== 1'b1) begin
            $display("%0t: strobe unknown: expected 0 or 1, actual %b", $time, rsp_strobe);
            error_count++;
         end else if (bytes_due.size() == 0) begin
            $display("%0t: unexpected byte: expected none, actual data %h last %b",
                     $time, rsp_item.data_byte, rsp_item.last);
            error_count++;
         end else begin
            due = bytes_due.pop_front();
            if (rsp_item.data_byte !== due.data_byte) begin
               $display("%0t: data_byte mismatch: expected %h, actual %h",
                        $time, due.data_byte, rsp_item.data_byte);
               error_count++;
            end
            if (rsp_item.last !== due.last) begin
               $display("%0t: last mismatch: expected %b, actual %b",
                        $time, due.last, rsp_item.last);
               error_count++;
            end
         end
      end
   end

   function automatic lmgfp_pkg::req_type make_item(
                                   input logic [1:0] kind,
                                   input logic [lmgfp_pkg::LED_ADDR_W-1:0] led_index,
                                   input logic [lmgfp_pkg::LEVEL_W-1:0] level,
                                   input logic [1:0] power_state);
      lmgfp_pkg::req_type item;
      item.kind        = kind;
      item.led_index   = led_index;
      item.level       = level;
      item.power_state = power_state;
      return item;
   endfunction

   // holds start and the item until an edge with busy low takes it
   task automatic send_item(input lmgfp_pkg::req_type item);
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predict_frame(item);
   endtask

   task automatic maybe_pause();
      if (gaps_enabled && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
   endtask

   task automatic test_reset_state();
      // all levels read zero, every column pattern in turn
      repeat (4) send_item(make_item(lmgfp_pkg::KIND_TICK, 6'd0, 4'd0, lmgfp_pkg::POWER_ON));
   endtask

   task automatic test_led_order();
      // bank edges show ascending order on even columns, descending on odd
      send_item(make_item(lmgfp_pkg::KIND_SET_ONE, 6'd0,  4'd15, lmgfp_pkg::POWER_OFF));
      send_item(make_item(lmgfp_pkg::KIND_SET_ONE, 6'd15, 4'd1,  lmgfp_pkg::POWER_ON));
      send_item(make_item(lmgfp_pkg::KIND_SET_ONE, 6'd16, 4'd14, POWER_TRANSIT));
      send_item(make_item(lmgfp_pkg::KIND_SET_ONE, 6'd31, 4'd2,  POWER_TRANSIT_ALT));
      send_item(make_item(lmgfp_pkg::KIND_SET_ONE, 6'd47, 4'd13, lmgfp_pkg::POWER_OFF));
      send_item(make_item(lmgfp_pkg::KIND_SET_ONE, 6'd63, 4'd15, lmgfp_pkg::POWER_ON));
      send_item(make_item(lmgfp_pkg::KIND_SET_ONE, 6'd33, 4'd10, lmgfp_pkg::POWER_OFF));
      repeat (4)
         send_item(make_item(lmgfp_pkg::KIND_TICK, 6'd63, 4'd15, lmgfp_pkg::POWER_ON));
   endtask

   task automatic test_power_states();
      // off holds the column, both transitional codes still advance it
      send_item(make_item(lmgfp_pkg::KIND_TICK, 6'd0,  4'd0,  lmgfp_pkg::POWER_OFF));
      send_item(make_item(lmgfp_pkg::KIND_TICK, 6'd21, 4'd5,  POWER_TRANSIT));
      send_item(make_item(lmgfp_pkg::KIND_TICK, 6'd42, 4'd10, POWER_TRANSIT_ALT));
      send_item(make_item(lmgfp_pkg::KIND_TICK, 6'd63, 4'd15, lmgfp_pkg::POWER_OFF));
      send_item(make_item(lmgfp_pkg::KIND_TICK, 6'd0,  4'd0,  lmgfp_pkg::POWER_ON));
   endtask

   task automatic test_ignored_kind();
      send_item(make_item(KIND_UNUSED, 6'd63, 4'd15, POWER_TRANSIT_ALT));
      send_item(make_item(lmgfp_pkg::KIND_TICK, 6'd0, 4'd0, lmgfp_pkg::POWER_ON));
   endtask

   task automatic test_set_all();
      send_item(make_item(lmgfp_pkg::KIND_SET_ALL, 6'd63, 4'd15, lmgfp_pkg::POWER_ON));
      send_item(make_item(lmgfp_pkg::KIND_TICK, 6'd0, 4'd0, lmgfp_pkg::POWER_ON));
      send_item(make_item(lmgfp_pkg::KIND_SET_ALL, 6'd0, 4'd0, POWER_TRANSIT));
   endtask

   function automatic lmgfp_pkg::req_type random_item();
      lmgfp_pkg::req_type item;
      int                 pick;
      item = lmgfp_pkg::req_type'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40)      item.kind = lmgfp_pkg::KIND_SET_ONE;
      else if (pick < 46) item.kind = lmgfp_pkg::KIND_SET_ALL;
      else if (pick < 95) item.kind = lmgfp_pkg::KIND_TICK;
      else                item.kind = KIND_UNUSED;
      if (item.kind == lmgfp_pkg::KIND_TICK) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)      item.power_state = lmgfp_pkg::POWER_ON;
         else if (pick < 80) item.power_state = lmgfp_pkg::POWER_OFF;
         else if (pick < 90) item.power_state = POWER_TRANSIT;
         else                item.power_state = POWER_TRANSIT_ALT;
      end
      return item;
   endfunction

   task automatic test_random_traffic();
      lmgfp_pkg::req_type item;
      int                 counted;
      int                 sent;
      counted = 0;
      sent    = 0;
      while (counted < RANDOM_ITEMS) begin
         // idling switches on and off in stretches, and stays off near the end
         if (sent % 20 == 0)
            gaps_enabled = (counted < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
         item = random_item();
         send_item(item);
         maybe_pause();
         sent++;
         if (item.kind != KIND_UNUSED) counted++;
      end
      gaps_enabled = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_led_order();
      test_power_states();
      test_ignored_kind();
      test_set_all();
      test_random_traffic();
      start <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      // catch any stray bytes after the last frame
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/lmgfp_pkg.sv
rtl/lmgfp_level_store.sv
rtl/lmgfp_sequencer.sv
rtl/lmgfp_datapath.sv
rtl/led_matrix_gray_frame_packer.sv
bench/tb_top.sv
